// ----- sv/mutf7_pkg.sv -----
// Package holding the beat types, state record and character constants of the decoder.
package mutf7_pkg;

  // One input beat: a data byte or an end-of-string marker.
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  // One result beat: a code point or an error mark.
  typedef struct packed {
    logic [20:0] code_point;
    logic        bad_input;
    logic        last_of_item;
  } out_item_t;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] bit_acc;
    logic        high_pend;
    logic [9:0]  high_bits;
  } dec_state_t;

  // Phase codes.
  localparam logic [3:0] PH_ASCII = 4'd0;
  localparam logic [3:0] PH_SHIFT = 4'd1;
  localparam logic [3:0] PH_BOUND = 4'd2;
  localparam logic [3:0] PH_3     = 4'd3;
  localparam logic [3:0] PH_4     = 4'd4;
  localparam logic [3:0] PH_5     = 4'd5;
  localparam logic [3:0] PH_6     = 4'd6;
  localparam logic [3:0] PH_7     = 4'd7;
  localparam logic [3:0] PH_8     = 4'd8;
  localparam logic [3:0] PH_9     = 4'd9;

  // Request type codes.
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Digit offsets and the two symbol digits.
  localparam logic [7:0] OFS_LOWER = 8'd71;
  localparam logic [7:0] OFS_DIGIT = 8'd4;
  localparam logic [5:0] DIG_PLUS  = 6'd62;
  localparam logic [5:0] DIG_COMMA = 6'd63;

  // Surrogate ranges and the supplementary plane base.
  localparam logic [15:0] SUR_HIGH_LO = 16'hD800;
  localparam logic [15:0] SUR_LOW_LO  = 16'hDC00;
  localparam logic [15:0] SUR_END     = 16'hE000;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // Result counts per input item.
  localparam logic [1:0] NRES_NONE = 2'd0;
  localparam logic [1:0] NRES_ONE  = 2'd1;
  localparam logic [1:0] NRES_TWO  = 2'd2;

endpackage

// ----- sv/mutf7_step.sv -----
// Combinational decode of one input beat against the current decoder state.
module mutf7_step (
  input  mutf7_pkg::in_item_t   item,
  input  mutf7_pkg::dec_state_t cur,
  output mutf7_pkg::dec_state_t nxt,
  output logic [1:0]            n_res,
  output mutf7_pkg::out_item_t  res0,
  output mutf7_pkg::out_item_t  res1
);

  logic [7:0]           c;
  logic [7:0]           dtmp;
  logic [5:0]           dval;
  logic                 is_dig;
  logic                 unit_fire;
  logic [15:0]          u;
  logic                 is_low;
  logic                 is_high;
  logic                 own_valid;
  mutf7_pkg::out_item_t own;
  mutf7_pkg::out_item_t err;

  assign c = item.in_byte;

  // Base64 digit value of the byte, or no digit at all.
  always_comb begin
    dtmp   = 8'd0;
    is_dig = 1'b1;
    if (c >= mutf7_pkg::CH_UP_A && c <= mutf7_pkg::CH_UP_Z) begin
      dtmp = c - mutf7_pkg::CH_UP_A;
    end else if (c >= mutf7_pkg::CH_LO_A && c <= mutf7_pkg::CH_LO_Z) begin
      dtmp = c - mutf7_pkg::OFS_LOWER;
    end else if (c >= mutf7_pkg::CH_ZERO && c <= mutf7_pkg::CH_NINE) begin
      dtmp = c + mutf7_pkg::OFS_DIGIT;
    end else if (c == mutf7_pkg::CH_PLUS) begin
      dtmp = {2'b00, mutf7_pkg::DIG_PLUS};
    end else if (c == mutf7_pkg::CH_COMMA) begin
      dtmp = {2'b00, mutf7_pkg::DIG_COMMA};
    end else begin
      is_dig = 1'b0;
    end
    dval = dtmp[5:0];
  end

  // Error mark beat, used wherever the input is rejected.
  always_comb begin
    err              = '0;
    err.bad_input    = 1'b1;
  end

  // Main decode: mode handling, digit gathering and unit completion.
  always_comb begin
    nxt       = cur;
    n_res     = mutf7_pkg::NRES_NONE;
    res0      = '0;
    res1      = '0;
    unit_fire = 1'b0;
    u         = '0;
    is_low    = 1'b0;
    is_high   = 1'b0;
    own       = '0;
    own_valid = 1'b0;

    if (item.req_type == mutf7_pkg::REQ_END) begin
      if (cur.phase != mutf7_pkg::PH_ASCII) begin
        n_res = mutf7_pkg::NRES_ONE;
        res0  = err;
      end
      nxt = '0;
    end else if (cur.phase == mutf7_pkg::PH_ASCII) begin
      if (c == mutf7_pkg::CH_AMP) begin
        nxt.phase = mutf7_pkg::PH_SHIFT;
      end else if (c >= mutf7_pkg::PRINT_LO && c <= mutf7_pkg::PRINT_HI) begin
        n_res           = mutf7_pkg::NRES_ONE;
        res0.code_point = {13'd0, c};
      end else begin
        n_res = mutf7_pkg::NRES_ONE;
        res0  = err;
      end
    end else if (!is_dig) begin
      // Leaving Base64, cleanly or not.
      if (c == mutf7_pkg::CH_DASH) begin
        case (cur.phase)
          mutf7_pkg::PH_SHIFT: begin
            n_res           = mutf7_pkg::NRES_ONE;
            res0.code_point = {13'd0, mutf7_pkg::CH_AMP};
          end
          mutf7_pkg::PH_3, mutf7_pkg::PH_4, mutf7_pkg::PH_6,
          mutf7_pkg::PH_7, mutf7_pkg::PH_9: begin
            n_res = mutf7_pkg::NRES_ONE;
            res0  = err;
          end
          default: begin
            if (cur.bit_acc != 16'd0 || cur.high_pend) begin
              n_res = mutf7_pkg::NRES_ONE;
              res0  = err;
            end
          end
        endcase
      end else begin
        n_res = mutf7_pkg::NRES_ONE;
        res0  = err;
      end
      nxt = '0;
    end else begin
      // Gather the digit into the current code unit.
      case (cur.phase)
        mutf7_pkg::PH_3: begin
          nxt.bit_acc = cur.bit_acc | {6'd0, dval, 4'd0};
          nxt.phase   = mutf7_pkg::PH_4;
        end
        mutf7_pkg::PH_4: begin
          unit_fire   = 1'b1;
          u           = cur.bit_acc | {12'd0, dval[5:2]};
          nxt.bit_acc = {dval[1:0], 14'd0};
          nxt.phase   = mutf7_pkg::PH_5;
        end
        mutf7_pkg::PH_5: begin
          nxt.bit_acc = cur.bit_acc | {2'd0, dval, 8'd0};
          nxt.phase   = mutf7_pkg::PH_6;
        end
        mutf7_pkg::PH_6: begin
          nxt.bit_acc = cur.bit_acc | {8'd0, dval, 2'd0};
          nxt.phase   = mutf7_pkg::PH_7;
        end
        mutf7_pkg::PH_7: begin
          unit_fire   = 1'b1;
          u           = cur.bit_acc | {14'd0, dval[5:4]};
          nxt.bit_acc = {dval[3:0], 12'd0};
          nxt.phase   = mutf7_pkg::PH_8;
        end
        mutf7_pkg::PH_8: begin
          nxt.bit_acc = cur.bit_acc | {4'd0, dval, 6'd0};
          nxt.phase   = mutf7_pkg::PH_9;
        end
        mutf7_pkg::PH_9: begin
          unit_fire   = 1'b1;
          u           = cur.bit_acc | {10'd0, dval};
          nxt.bit_acc = 16'd0;
          nxt.phase   = mutf7_pkg::PH_BOUND;
        end
        default: begin
          nxt.bit_acc = {dval, 10'd0};
          nxt.phase   = mutf7_pkg::PH_3;
        end
      endcase

      // Surrogate classification of a completed code unit.
      is_low  = (u >= mutf7_pkg::SUR_LOW_LO) && (u < mutf7_pkg::SUR_END);
      is_high = (u >= mutf7_pkg::SUR_HIGH_LO) && (u < mutf7_pkg::SUR_LOW_LO);

      // A completed unit: join a pair, or handle it on its own.
      if (unit_fire) begin
        if (cur.high_pend && is_low) begin
          n_res           = mutf7_pkg::NRES_ONE;
          res0.code_point = {1'b0, cur.high_bits, u[9:0]} + mutf7_pkg::SUPP_BASE;
          nxt.high_pend   = 1'b0;
          nxt.high_bits   = 10'd0;
        end else begin
          if (is_high) begin
            nxt.high_pend = 1'b1;
            nxt.high_bits = u[9:0];
          end else begin
            nxt.high_pend = 1'b0;
            nxt.high_bits = 10'd0;
            own_valid     = 1'b1;
            if (is_low || (u >= {8'd0, mutf7_pkg::PRINT_LO} &&
                           u <= {8'd0, mutf7_pkg::PRINT_HI} &&
                           u != {8'd0, mutf7_pkg::CH_AMP})) begin
              own = err;
            end else begin
              own.code_point = {5'd0, u};
            end
          end
          // A broken pair is flagged ahead of the new unit's own result.
          if (cur.high_pend) begin
            res0  = err;
            res1  = own;
            n_res = own_valid ? mutf7_pkg::NRES_TWO : mutf7_pkg::NRES_ONE;
          end else begin
            res0  = own;
            n_res = own_valid ? mutf7_pkg::NRES_ONE : mutf7_pkg::NRES_NONE;
          end
        end
      end
    end

    // Mark the final result of this item.
    if (n_res == mutf7_pkg::NRES_ONE) begin
      res0.last_of_item = 1'b1;
    end else if (n_res == mutf7_pkg::NRES_TWO) begin
      res1.last_of_item = 1'b1;
    end
  end

endmodule

// ----- sv/mutf7_out_queue.sv -----
// Four-entry result queue: takes up to two beats a cycle, gives one beat a cycle unless res_stall holds it.
module mutf7_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_n,
  input  mutf7_pkg::out_item_t push0,
  input  mutf7_pkg::out_item_t push1,
  output logic                 room,
  output logic                 res_valid,
  input  logic                 res_stall,
  output mutf7_pkg::out_item_t res_data
);

  mutf7_pkg::out_item_t entry [4];
  logic [1:0]           wr_ptr;
  logic [1:0]           rd_ptr;
  logic [2:0]           count;
  logic [2:0]           count_next;
  logic                 pop;
  logic [1:0]           wr_ptr_p1;

  // Room for a worst-case item of two results.
  assign room      = (count <= 3'd2);
  assign res_valid = (count != 3'd0);
  assign res_data  = entry[rd_ptr];
  assign pop       = res_valid && !res_stall;
  assign wr_ptr_p1 = wr_ptr + 2'd1;

  assign count_next = count + {1'b0, push_n} - {2'b00, pop};

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_n != mutf7_pkg::NRES_NONE) begin
      entry[wr_ptr] <= push0;
    end
    if (push_n == mutf7_pkg::NRES_TWO) begin
      entry[wr_ptr_p1] <= push1;
    end
  end

  // The queue must never be pushed past its depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != mutf7_pkg::NRES_NONE) |-> room)
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue count out of range");

  a_pointer_gap: assert property (@(posedge clk) disable iff (rst)
    (count != 3'd4) |-> (count[1:0] == (wr_ptr - rd_ptr)))
    else $error("result queue pointers disagree with count");

endmodule

// ----- sv/mutf7_imap_byte_decoder_unit.sv -----
// Top level of the IMAP modified UTF-7 byte decoder.
//
// The req channel carries one beat per encoded byte, or an end-of-string
// marker (req_type high). The res channel carries decoded code points and
// error marks; last_of_item flags the final result caused by one input beat.
// An input beat gives no, one or two results.
//
// An accepted beat is held in the input register, where the decoder state
// and the byte are decoded together; its results enter a four-entry
// result queue at the end of a cycle in which the queue has room, and are
// offered on res from the cycle after. One input beat is taken every cycle
// while the queue has room and results drain at one per cycle; an item
// with two results occupies one output beat per result, and the rate is
// set by the single output beat per cycle of the result queue.
//
// Reset clears the input register, the result queue and the decoder state
// (ASCII mode, nothing pending). When the receiver stalls, the current res
// beat holds and the queue fills; req_stall rises once the queue cannot take
// another two results behind an item already in the input register.
module mutf7_imap_byte_decoder_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  mutf7_pkg::in_item_t  req_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output mutf7_pkg::out_item_t res_data
);

  logic                  in_full;
  mutf7_pkg::in_item_t   in_q;
  mutf7_pkg::dec_state_t st;
  mutf7_pkg::dec_state_t st_next;
  logic [1:0]            n_res;
  mutf7_pkg::out_item_t  res0;
  mutf7_pkg::out_item_t  res1;
  logic                  room;
  logic                  advance;
  logic [1:0]            push_n;

  // The held beat moves on when the queue has room for its results.
  assign advance   = in_full && room;
  assign req_stall = in_full && !room;
  assign push_n    = advance ? n_res : mutf7_pkg::NRES_NONE;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_full || advance) begin
      in_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_q <= req_data;
    end
  end

  // Decoder state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  mutf7_step u_step (
    .item  (in_q),
    .cur   (st),
    .nxt   (st_next),
    .n_res (n_res),
    .res0  (res0),
    .res1  (res1)
  );

  mutf7_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // Phase codes above nine are never reached.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.phase <= mutf7_pkg::PH_9)
    else $error("decoder phase out of range");

  // In ASCII mode nothing is gathered and no surrogate is pending.
  a_ascii_clean: assert property (@(posedge clk) disable iff (rst)
    (st.phase == mutf7_pkg::PH_ASCII) |-> (st.bit_acc == 16'd0 && !st.high_pend))
    else $error("ASCII mode with leftover Base64 state");

  // Nothing is offered on the result side right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered after reset");

endmodule
